[src/spq_pkg.sv]
// ---------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Word formats of the request and response channels, action codes and the
// slot record passed between neighboring cells.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_APPEND  = 2'd1;
  localparam logic [1:0] ACT_DEQUEUE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] priority_req;
    logic [15:0] tag;
  } req_word_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] out_tag;
    logic        now_empty;
    logic        now_full;
    logic [4:0]  entry_count;
  } rsp_word_t;

  // contents of one cell
  typedef struct packed {
    logic        valid;
    logic [15:0] prio;
    logic [15:0] tag;
  } slot_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic        ins;     // ordered insert
    logic        app;     // append at back
    logic        deq;     // remove front
    logic [15:0] prio;
    logic [15:0] tag;
  } cell_op_t;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// ---------------------------------------------------------------------------
// spq_cell: one slot of the queue
// Holds one entry. On insert or append it keeps, takes the new entry or
// takes its left neighbor; on dequeue it takes its right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spq_pkg::cell_op_t op,
  input  wire spq_pkg::slot_t   left,
  input  wire spq_pkg::slot_t   right,
  input  wire logic             found_in,
  output spq_pkg::slot_t        slot,
  output logic                  found_out
);
  import spq_pkg::*;

  logic  mark;
  slot_t slot_next;

  // first marked cell is the insert point; empty cells are contiguous at back
  always_comb begin
    if (op.app) begin
      mark = !slot.valid;
    end else begin
      mark = !slot.valid || (slot.prio > op.prio);
    end
  end

  assign found_out = found_in || mark;

  always_comb begin
    slot_next = slot;
    if (op.ins || op.app) begin
      if (found_in) begin
        slot_next = left;
      end else if (mark) begin
        slot_next.valid = 1'b1;
        slot_next.prio  = op.prio;
        slot_next.tag   = op.tag;
      end
    end else if (op.deq) begin
      slot_next = right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.prio <= slot_next.prio;
    slot.tag  <= slot_next.tag;
  end

endmodule

`default_nettype wire

[src/sorted_priority_queue.sv]
// ---------------------------------------------------------------------------
// sorted_priority_queue: bounded ordered queue of (priority, tag) entries
// A row of CAPACITY cells kept front to back; inserts shift the tail right,
// dequeues shift the whole row left.
//
//   channel  direction  handshake          word
//   req      in         req_valid/stall    action, priority_req, tag
//   rsp      out        rsp_valid/stall    accepted, out_tag, flags, count
//
// A word is taken per cycle unless stalled; each gets a registered response.
// The insert point comes from a compare in every cell and a found chain
// through the row, which sets the cycle time.
// Reset empties the queue at once; slot contents are not cleared.
// A stalled response holds req_stall high until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire spq_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output spq_pkg::rsp_word_t      rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  slot_t       slots [CAPACITY];
  logic        found [CAPACITY+1];
  cell_op_t    op;
  logic        take;
  logic        full;
  logic        empty;
  logic        ok;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW+4:0] count_ext;
  rsp_word_t   rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign take      = req_valid && !req_stall;
  assign full      = slots[CAPACITY-1].valid;
  assign empty     = !slots[0].valid;

  always_comb begin
    op      = '0;
    op.prio = req.priority_req;
    op.tag  = req.tag;
    ok      = 1'b0;
    if (take) begin
      unique case (req.action)
        ACT_INSERT: begin
          op.ins = !full;
          ok     = !full;
        end
        ACT_APPEND: begin
          op.app = !full;
          ok     = !full;
        end
        ACT_DEQUEUE: begin
          op.deq = !empty;
          ok     = !empty;
        end
        default: ;
      endcase
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left;
    slot_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = slots[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .left      (left),
      .right     (right),
      .found_in  (found[i]),
      .slot      (slots[i]),
      .found_out (found[i+1])
    );
  end

  always_comb begin
    count_next = count;
    if (op.ins || op.app) begin
      count_next = count + CW'(1);
    end else if (op.deq) begin
      count_next = count - CW'(1);
    end
  end

  assign count_ext = {5'b0, count_next};

  always_comb begin
    rsp_next.accepted    = ok;
    rsp_next.out_tag     = op.deq ? slots[0].tag : 16'd0;
    rsp_next.now_empty   = (count_next == '0);
    rsp_next.now_full    = (count_next == CW'(CAPACITY));
    rsp_next.entry_count = count_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (take) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
